/* rtl/scb_pkg.sv */
`default_nettype none

package scb_pkg;

   // Screen geometry: the screen covers [0, SCREEN_DIM-1] on both axes
   localparam int SCREEN_DIM = 160;
   localparam int EDGE       = SCREEN_DIM - 1;

   // Datapath widths
   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;    // endpoint difference, sign-extended coordinates
   localparam int OFF_W   = COORD_W + 2;    // screen edge minus coordinate
   localparam int PROD_W  = DIFF_W + OFF_W;
   localparam int CROSS_W = PROD_W + 1;

   localparam logic signed [DIFF_W-1:0] EDGE_S = DIFF_W'(EDGE);
   localparam logic signed [OFF_W-1:0]  EDGE_O = OFF_W'(EDGE);

   // Orientation of an ordered point triple
   typedef enum logic [1:0] {
      ORI_COL = 2'd0,
      ORI_CW  = 2'd1,
      ORI_CCW = 2'd2
   } orient_type;

   typedef orient_type [3:0] orient4_type;

   // Border numbering
   localparam int B_TOP    = 0;
   localparam int B_RIGHT  = 1;
   localparam int B_BOTTOM = 2;
   localparam int B_LEFT   = 3;

   // Corner numbering: 0 (0,0), 1 (e,0), 2 (e,e), 3 (0,e)
   localparam logic [1:0] CORNER_00 = 2'd0;
   localparam logic [1:0] CORNER_E0 = 2'd1;
   localparam logic [1:0] CORNER_EE = 2'd2;
   localparam logic [1:0] CORNER_0E = 2'd3;

   // First and second corner of each border, in border order
   localparam logic [1:0] BORDER_C [4] = '{CORNER_00, CORNER_E0, CORNER_0E, CORNER_00};
   localparam logic [1:0] BORDER_D [4] = '{CORNER_E0, CORNER_EE, CORNER_EE, CORNER_0E};

   // Flags that ride along the pipeline from the first stage
   typedef struct packed {
      logic        reject;      // bounding box wholly off screen
      logic [1:0]  x_in;        // segment x range holds 0 / e
      logic [1:0]  y_in;        // segment y range holds 0 / e
      orient4_type ob_a;        // border against start point
      orient4_type ob_b;        // border against end point
      logic [3:0]  on_a;        // start point lies on border
      logic [3:0]  on_b;        // end point lies on border
   } flags_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [OFF_W-1:0]  off_x0;
      logic signed [OFF_W-1:0]  off_xe;
      logic signed [OFF_W-1:0]  off_y0;
      logic signed [OFF_W-1:0]  off_ye;
      flags_type                flags;
   } s1_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] p_y0;   // dy * (0 - end_x)
      logic signed [PROD_W-1:0] p_ye;   // dy * (e - end_x)
      logic signed [PROD_W-1:0] p_x0;   // dx * (0 - end_y)
      logic signed [PROD_W-1:0] p_xe;   // dx * (e - end_y)
      flags_type                flags;
   } s2_type;

   typedef struct packed {
      orient4_type oc;          // segment against each corner
      flags_type   flags;
   } s3_type;

   // Orientation code from the sign of a cross product
   function automatic orient_type sign_code(input logic neg, input logic zero);
      orient_type r;
      if (zero) begin
         r = ORI_COL;
      end else if (neg) begin
         r = ORI_CCW;
      end else begin
         r = ORI_CW;
      end
      return r;
   endfunction

   // Orientation of each border (axis aligned) against one point
   function automatic orient4_type pt_orient(input logic signed [DIFF_W-1:0] x,
                                             input logic signed [DIFF_W-1:0] y);
      orient4_type r;
      r[B_TOP]    = sign_code(y > 0, y == 0);
      r[B_RIGHT]  = sign_code(x < EDGE_S, x == EDGE_S);
      r[B_BOTTOM] = sign_code(y > EDGE_S, y == EDGE_S);
      r[B_LEFT]   = sign_code(x < 0, x == 0);
      return r;
   endfunction

   // Whether one point lies on each border segment
   function automatic logic [3:0] pt_on(input logic signed [DIFF_W-1:0] x,
                                        input logic signed [DIFF_W-1:0] y);
      logic       xr;
      logic       yr;
      logic [3:0] r;
      xr = (x >= 0) && (x <= EDGE_S);
      yr = (y >= 0) && (y <= EDGE_S);
      r[B_TOP]    = xr && (y == 0);
      r[B_RIGHT]  = yr && (x == EDGE_S);
      r[B_BOTTOM] = xr && (y == EDGE_S);
      r[B_LEFT]   = yr && (x == 0);
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/scb_front.sv */
`default_nettype none

module scb_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [4*scb_pkg::COORD_W-1:0] in_data,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output scb_pkg::s1_type                    out_data
);

   logic                                 valid_ff;
   scb_pkg::s1_type                      data_ff;
   scb_pkg::s1_type                      data_in;
   logic signed [scb_pkg::DIFF_W-1:0]    sx;
   logic signed [scb_pkg::DIFF_W-1:0]    sy;
   logic signed [scb_pkg::DIFF_W-1:0]    ex;
   logic signed [scb_pkg::DIFF_W-1:0]    ey;

   // Sign-extend the coordinates
   always_comb begin
      sx = scb_pkg::DIFF_W'($signed(in_data[scb_pkg::COORD_W-1:0]));
      sy = scb_pkg::DIFF_W'($signed(in_data[2*scb_pkg::COORD_W-1:scb_pkg::COORD_W]));
      ex = scb_pkg::DIFF_W'($signed(in_data[3*scb_pkg::COORD_W-1:2*scb_pkg::COORD_W]));
      ey = scb_pkg::DIFF_W'($signed(in_data[4*scb_pkg::COORD_W-1:3*scb_pkg::COORD_W]));
   end

   // Form differences, corner offsets and the border flags
   always_comb begin
      data_in.dx     = ex - sx;
      data_in.dy     = ey - sy;
      data_in.off_x0 = scb_pkg::OFF_W'(0) - scb_pkg::OFF_W'(ex);
      data_in.off_xe = scb_pkg::EDGE_O - scb_pkg::OFF_W'(ex);
      data_in.off_y0 = scb_pkg::OFF_W'(0) - scb_pkg::OFF_W'(ey);
      data_in.off_ye = scb_pkg::EDGE_O - scb_pkg::OFF_W'(ey);

      data_in.flags.reject = ((sx < 0) && (ex < 0)) || ((sy < 0) && (ey < 0)) ||
                             ((sx > scb_pkg::EDGE_S) && (ex > scb_pkg::EDGE_S)) ||
                             ((sy > scb_pkg::EDGE_S) && (ey > scb_pkg::EDGE_S));

      data_in.flags.x_in[0] = !((sx > 0) && (ex > 0)) && !((sx < 0) && (ex < 0));
      data_in.flags.x_in[1] = !((sx > scb_pkg::EDGE_S) && (ex > scb_pkg::EDGE_S)) &&
                              !((sx < scb_pkg::EDGE_S) && (ex < scb_pkg::EDGE_S));
      data_in.flags.y_in[0] = !((sy > 0) && (ey > 0)) && !((sy < 0) && (ey < 0));
      data_in.flags.y_in[1] = !((sy > scb_pkg::EDGE_S) && (ey > scb_pkg::EDGE_S)) &&
                              !((sy < scb_pkg::EDGE_S) && (ey < scb_pkg::EDGE_S));

      data_in.flags.ob_a = scb_pkg::pt_orient(sx, sy);
      data_in.flags.ob_b = scb_pkg::pt_orient(ex, ey);
      data_in.flags.on_a = scb_pkg::pt_on(sx, sy);
      data_in.flags.on_b = scb_pkg::pt_on(ex, ey);
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance the stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/scb_mult.sv */
`default_nettype none

module scb_mult (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire scb_pkg::s1_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output scb_pkg::s2_type      out_data
);

   logic            valid_ff;
   scb_pkg::s2_type data_ff;
   scb_pkg::s2_type data_in;

   // Four cross-product terms, each shared by two of the four corners
   always_comb begin
      data_in.p_y0  = scb_pkg::PROD_W'(in_data.dy) * scb_pkg::PROD_W'(in_data.off_x0);
      data_in.p_ye  = scb_pkg::PROD_W'(in_data.dy) * scb_pkg::PROD_W'(in_data.off_xe);
      data_in.p_x0  = scb_pkg::PROD_W'(in_data.dx) * scb_pkg::PROD_W'(in_data.off_y0);
      data_in.p_xe  = scb_pkg::PROD_W'(in_data.dx) * scb_pkg::PROD_W'(in_data.off_ye);
      data_in.flags = in_data.flags;
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance the stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/scb_orient.sv */
`default_nettype none

module scb_orient (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire scb_pkg::s2_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output scb_pkg::s3_type      out_data
);

   logic                               valid_ff;
   scb_pkg::s3_type                    data_ff;
   scb_pkg::s3_type                    data_in;
   logic signed [scb_pkg::CROSS_W-1:0] v [4];

   // Cross product of the segment with each screen corner
   always_comb begin
      v[scb_pkg::CORNER_00] = scb_pkg::CROSS_W'(in_data.p_y0) - scb_pkg::CROSS_W'(in_data.p_x0);
      v[scb_pkg::CORNER_E0] = scb_pkg::CROSS_W'(in_data.p_ye) - scb_pkg::CROSS_W'(in_data.p_x0);
      v[scb_pkg::CORNER_EE] = scb_pkg::CROSS_W'(in_data.p_ye) - scb_pkg::CROSS_W'(in_data.p_xe);
      v[scb_pkg::CORNER_0E] = scb_pkg::CROSS_W'(in_data.p_y0) - scb_pkg::CROSS_W'(in_data.p_xe);
      for (int k = 0; k < 4; k++) begin
         data_in.oc[k] = scb_pkg::sign_code(v[k] < 0, v[k] == 0);
      end
      data_in.flags = in_data.flags;
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance the stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/segment_crosses_screen_border_unit.sv */
// Throughput: one item per cycle while the output is not stalled; set by four register
// stages (offsets, products, corner orientation, border combine) that each hold one item.
// Stalls: each stage holds its item while the next one is full and not taken.
// Reset: synchronous, active high; clears every stage valid bit, payload is not reset.
`default_nettype none

module segment_crosses_screen_border_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // crosses[0], zero fill [7:1]
);

   logic            s1_valid;
   logic            s1_ready;
   scb_pkg::s1_type s1_data;
   logic            s2_valid;
   logic            s2_ready;
   scb_pkg::s2_type s2_data;
   logic            s3_valid;
   logic            s3_ready;
   scb_pkg::s3_type s3_data;

   logic            out_valid_ff;
   logic            crosses_ff;
   logic            crosses_in;
   logic [3:0]      meet;
   logic [3:0]      c_in;

   scb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   scb_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   scb_orient u_orient (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   // Corner inside the segment's bounding box
   always_comb begin
      c_in[scb_pkg::CORNER_00] = s3_data.flags.x_in[0] && s3_data.flags.y_in[0];
      c_in[scb_pkg::CORNER_E0] = s3_data.flags.x_in[1] && s3_data.flags.y_in[0];
      c_in[scb_pkg::CORNER_EE] = s3_data.flags.x_in[1] && s3_data.flags.y_in[1];
      c_in[scb_pkg::CORNER_0E] = s3_data.flags.x_in[0] && s3_data.flags.y_in[1];
   end

   // Combine the orientations per border: proper crossing or collinear touch
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         meet[k] =
            ((s3_data.oc[scb_pkg::BORDER_C[k]] != s3_data.oc[scb_pkg::BORDER_D[k]]) &&
             (s3_data.flags.ob_a[k] != s3_data.flags.ob_b[k])) ||
            ((s3_data.oc[scb_pkg::BORDER_C[k]] == scb_pkg::ORI_COL) &&
             c_in[scb_pkg::BORDER_C[k]]) ||
            ((s3_data.oc[scb_pkg::BORDER_D[k]] == scb_pkg::ORI_COL) &&
             c_in[scb_pkg::BORDER_D[k]]) ||
            ((s3_data.flags.ob_a[k] == scb_pkg::ORI_COL) && s3_data.flags.on_a[k]) ||
            ((s3_data.flags.ob_b[k] == scb_pkg::ORI_COL) && s3_data.flags.on_b[k]);
      end
      crosses_in = !s3_data.flags.reject && (|meet);
   end

   assign s3_ready = !out_valid_ff || rsp_tready;

   // Output register valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         out_valid_ff <= s3_valid;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (s3_ready && s3_valid) begin
         crosses_ff <= crosses_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, crosses_ff};

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // A held result must block the last stage
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && !rsp_tready && s3_ready))
      else $error("last stage advances over a held result");

   // A segment whose box is off screen never reports a crossing
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (s3_valid && s3_ready && s3_data.flags.reject) |=> (rsp_tvalid && !rsp_tdata[0]))
      else $error("off-screen segment reported as crossing");

endmodule

`default_nettype wire

/* dv/segment_crosses_border_check.sv */
`timescale 1ns / 1ps

module segment_crosses_border_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,   // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,   // crosses[0], zero fill [7:1]
   output int               mismatch_count,
   output int               awaiting_count
);

   // Crossing answers still owed by the block, oldest first
   logic pending_crosses [$];
   logic owed_crosses;

   initial begin
      mismatch_count = 0;
      awaiting_count = 0;
   end

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Turn of the ordered triple p, q, r from the sign of the cross product
   function automatic scb_pkg::orient_type triple_turn(input longint px, input longint py,
                                                       input longint qx, input longint qy,
                                                       input longint rx, input longint ry);
      longint v;
      v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
      if (v == 0) begin
         return scb_pkg::ORI_COL;
      end else if (v > 0) begin
         return scb_pkg::ORI_CW;
      end
      return scb_pkg::ORI_CCW;
   endfunction

   // Point q inside the box spanned by p and r
   function automatic bit within_box(input longint px, input longint py,
                                     input longint qx, input longint qy,
                                     input longint rx, input longint ry);
      return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
             qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
   endfunction

   // Segments a-b and c-d cross or touch
   function automatic bit segments_meet(input longint ax, input longint ay,
                                        input longint bx, input longint by,
                                        input longint cx, input longint cy,
                                        input longint dx, input longint dy);
      scb_pkg::orient_type o1;
      scb_pkg::orient_type o2;
      scb_pkg::orient_type o3;
      scb_pkg::orient_type o4;
      o1 = triple_turn(ax, ay, bx, by, cx, cy);
      o2 = triple_turn(ax, ay, bx, by, dx, dy);
      o3 = triple_turn(cx, cy, dx, dy, ax, ay);
      o4 = triple_turn(cx, cy, dx, dy, bx, by);
      if (o1 != o2 && o3 != o4) return 1'b1;
      // collinear cases: an endpoint of one lies on the other
      if (o1 == scb_pkg::ORI_COL && within_box(ax, ay, cx, cy, bx, by)) return 1'b1;
      if (o2 == scb_pkg::ORI_COL && within_box(ax, ay, dx, dy, bx, by)) return 1'b1;
      if (o3 == scb_pkg::ORI_COL && within_box(cx, cy, ax, ay, dx, dy)) return 1'b1;
      if (o4 == scb_pkg::ORI_COL && within_box(cx, cy, bx, by, dx, dy)) return 1'b1;
      return 1'b0;
   endfunction

   // Whether the segment in one item meets any screen border
   function automatic logic predict_crosses(input logic [63:0] seg);
      longint sx;
      longint sy;
      longint ex;
      longint ey;
      longint e;
      sx = longint'($signed(seg[15:0]));
      sy = longint'($signed(seg[31:16]));
      ex = longint'($signed(seg[47:32]));
      ey = longint'($signed(seg[63:48]));
      e  = longint'(scb_pkg::EDGE);
      // drop segments whose box lies wholly off screen
      if (((sx > ex) ? sx : ex) < 0 || ((sy > ey) ? sy : ey) < 0 ||
          ((sx < ex) ? sx : ex) > e || ((sy < ey) ? sy : ey) > e) begin
         return 1'b0;
      end
      return segments_meet(sx, sy, ex, ey, 0, 0, e, 0) ||
             segments_meet(sx, sy, ex, ey, e, 0, e, e) ||
             segments_meet(sx, sy, ex, ey, 0, e, e, e) ||
             segments_meet(sx, sy, ex, ey, 0, 0, 0, e);
   endfunction

   // Compare each result against the oldest answer, then log the new item
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_crosses.size() == 0) begin
               report_mismatch($sformatf("result %0b with no item pending", rsp_tdata[0]));
            end else begin
               owed_crosses = pending_crosses.pop_front();
               if (rsp_tdata[0] !== owed_crosses) begin
                  report_mismatch($sformatf("crosses %0b, expected %0b",
                                            rsp_tdata[0], owed_crosses));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_crosses.push_back(predict_crosses(req_tdata));
         end
         awaiting_count = pending_crosses.size();
      end
   end

endmodule

/* dv/tb_segment_crosses_screen_border_unit.sv */
`timescale 1ns / 1ps

module tb_segment_crosses_screen_border_unit;

   localparam int RANDOM_PER_PHASE = 250;
   localparam int BURST_ITEMS      = 40;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 10;
   localparam int SEND_IDLE  [4]   = '{0, 57, 0, 13};
   localparam int RECV_STALL [4]   = '{0, 0, 57, 13};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // crosses[0], zero fill [7:1]

   int mismatch_count;
   int awaiting_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_asks;
   int hold_seen;
   int hold_left;

   segment_crosses_screen_border_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   segment_crosses_border_check u_border_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .awaiting_count (awaiting_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // End a hung run
   initial begin
      #1600000;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: stall at random, or hold off for a long stretch when asked
   initial begin
      rsp_tready = 1'b0;
      hold_seen  = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [63:0] pack_segment(input int sx, input int sy,
                                                input int ex, input int ey);
      return {16'(ey), 16'(ex), 16'(sy), 16'(sx)};
   endfunction

   // Random segment: wide range, near the screen, on border values, or degenerate
   function automatic logic [63:0] random_segment();
      int          snap [6] = '{-1, 0, 1, scb_pkg::EDGE - 1, scb_pkg::EDGE,
                                scb_pkg::SCREEN_DIM};
      int          pick;
      logic [15:0] w [4];
      pick = $urandom_range(99);
      for (int i = 0; i < 4; i++) begin
         if (pick < 20) begin
            w[i] = 16'($urandom);
         end else if (pick < 60 || $urandom_range(1) == 0) begin
            w[i] = 16'(int'($urandom_range(scb_pkg::SCREEN_DIM + 80)) - 40);
         end else begin
            w[i] = 16'(snap[$urandom_range(5)]);
         end
      end
      // axis aligned or single point
      if (pick >= 85) begin
         case ($urandom_range(2))
            0: w[2] = w[0];
            1: w[3] = w[1];
            default: begin
               w[2] = w[0];
               w[3] = w[1];
            end
         endcase
      end
      return {w[3], w[2], w[1], w[0]};
   endfunction

   // Offer one item, with idle cycles first; return at the falling edge after acceptance
   task automatic send_segment(input logic [63:0] seg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= seg;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop offering and wait until every answer has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (awaiting_count == 0);
      @(negedge clock);
   endtask

   // Stimulus
   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asks      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // field extremes
      send_segment(pack_segment(-32768, -32768, -32768, -32768));
      send_segment(pack_segment(32767, 32767, 32767, 32767));
      send_segment(pack_segment(-32768, -32768, 32767, 32767));
      send_segment(pack_segment(-32768, 32767, 32767, -32768));
      send_segment(pack_segment(-32768, 80, 32767, 80));
      send_segment(pack_segment(80, -32768, 80, 32767));
      // single points: corner, on a border, inside, just outside
      send_segment(pack_segment(0, 0, 0, 0));
      send_segment(pack_segment(scb_pkg::EDGE, 80, scb_pkg::EDGE, 80));
      send_segment(pack_segment(80, 80, 80, 80));
      send_segment(pack_segment(scb_pkg::SCREEN_DIM, scb_pkg::SCREEN_DIM,
                                scb_pkg::SCREEN_DIM, scb_pkg::SCREEN_DIM));
      send_segment(pack_segment(-1, 50, -1, 50));
      // collinear with a border: overlapping, touching at an end, off to one side
      send_segment(pack_segment(-10, 0, 5, 0));
      send_segment(pack_segment(scb_pkg::EDGE, 0, 300, 0));
      send_segment(pack_segment(scb_pkg::SCREEN_DIM, 0, 300, 0));
      send_segment(pack_segment(-5, 0, -1, 0));
      send_segment(pack_segment(0, -20, 0, 200));
      // strictly inside, leaving the screen, corner touch, clean diagonal crossing
      send_segment(pack_segment(10, 10, 100, 100));
      send_segment(pack_segment(80, 80, 80, 500));
      send_segment(pack_segment(scb_pkg::EDGE, scb_pkg::EDGE, 200, 200));
      send_segment(pack_segment(-100, -100, 300, 300));
      // box overlaps the screen but the segment misses it
      send_segment(pack_segment(100, -100, 300, 100));
      send_segment(pack_segment(-100, 100, 100, 300));
      // touching a border from inside, and stopping just short of one
      send_segment(pack_segment(1, 1, scb_pkg::EDGE, 50));
      send_segment(pack_segment(1, 1, scb_pkg::EDGE - 1, scb_pkg::EDGE - 1));
      drain_results();

      // hold the receiver off while items keep coming, so the input backs up
      hold_asks++;
      repeat (BURST_ITEMS) send_segment(random_segment());
      drain_results();

      // random items under each idling pattern
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = SEND_IDLE[p];
         recv_stall_pct = RECV_STALL[p];
         repeat (RANDOM_PER_PHASE) send_segment(random_segment());
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* segment_crosses_screen_border_unit.f */
rtl/scb_pkg.sv
rtl/scb_front.sv
rtl/scb_mult.sv
rtl/scb_orient.sv
rtl/segment_crosses_screen_border_unit.sv
dv/segment_crosses_border_check.sv
dv/tb_segment_crosses_screen_border_unit.sv
